[rtl/core/mouse_report_gesture_classifier_top_assert.svh]
// Assertion macros shared by the mouse report gesture classifier RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MOUSE_REPORT_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define MOUSE_REPORT_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// Concurrent check, masked while reset is asserted
`define MRGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that also holds during reset
`define MRGC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mrgc_pkg.sv]
// Types and constants for the mouse report gesture classifier.
// No dependencies; imported by every module of the block.
package mrgc_pkg;

	localparam logic [7:0]  VALID_ID  = 8'h02;
	localparam logic [31:0] RESET_X   = 32'd320;
	localparam logic [31:0] RESET_Y   = 32'd240;
	localparam logic [31:0] RESET_SCR = 32'd240;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_MOVE    = 3'd1,
		EV_PRESS   = 3'd2,
		EV_CLICK   = 3'd3,
		EV_RELEASE = 3'd4,
		EV_SCROLL  = 3'd5,
		EV_BAD     = 3'd6
	} ev_kind_t;

	typedef enum logic [1:0] {
		BTN_LEFT  = 2'd0,
		BTN_RIGHT = 2'd1,
		BTN_WHEEL = 2'd2
	} btn_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BUTTON = 2'd1,
		MODE_WHEEL  = 2'd2
	} mode_t;

	// One mouse report
	typedef struct packed {
		logic [7:0]         report_id;
		logic               left_down;
		logic               right_down;
		logic               wheel_down;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic signed [15:0] delta_wheel;
	} report_t;

	// One classified gesture
	typedef struct packed {
		ev_kind_t           event_kind;
		btn_t               event_button;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic signed [15:0] scroll_amount;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] scroll_position;
		mode_t              mouse_mode;
	} gesture_t;

	// Tracker state carried from report to report
	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] scroll_acc;
		logic        left_held;
		logic        right_held;
		logic        wheel_held;
		logic        press_seen;
		mode_t       mode;
	} state_t;

	localparam state_t STATE_RESET = '{
		pos_x:      RESET_X,
		pos_y:      RESET_Y,
		scroll_acc: RESET_SCR,
		left_held:  1'b0,
		right_held: 1'b0,
		wheel_held: 1'b0,
		press_seen: 1'b0,
		mode:       MODE_NORMAL
	};

	// Handshake between input register and classifier stage
	typedef struct packed {
		logic valid;
		logic load;
	} stage_ctl_t;

endpackage

[rtl/core/mrgc_input_stage.sv]
// Input register of the gesture classifier: holds one report for the classifier.
// Depends on mrgc_pkg.
module mrgc_input_stage import mrgc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    report_valid,
	output logic    report_stall,
	input  report_t report,
	input  logic    load,
	output logic    valid_s1,
	output report_t item_s1
);

	logic take;

	// Accept when empty or when the held item moves on this cycle
	assign report_stall = valid_s1 && !load;
	assign take         = report_valid && !report_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= report;
		end
	end

endmodule

[rtl/core/mrgc_classifier.sv]
// Classifier stage: tracker state, priority chain and result register.
// Depends on mrgc_pkg and mouse_report_gesture_classifier_top_assert.svh.
`include "mouse_report_gesture_classifier_top_assert.svh"
module mrgc_classifier import mrgc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  report_t    item_s1,
	input  stage_ctl_t ctl,
	output logic       gesture_valid,
	input  logic       gesture_stall,
	output gesture_t   gesture
);

	state_t   state_q;
	state_t   nxt;
	gesture_t res;
	logic     is_move;
	logic     any_xy;

	assign any_xy = (item_s1.delta_x != 16'sd0) || (item_s1.delta_y != 16'sd0);

	// Next state and result for the report in the input register
	always_comb begin
		nxt                 = state_q;
		res                 = '0;
		res.event_kind      = EV_NONE;
		res.event_button    = BTN_LEFT;
		is_move             = 1'b0;
		if (item_s1.report_id != VALID_ID) begin
			res.event_kind = EV_BAD;
		end else begin
			nxt.pos_x      = state_q.pos_x + {{16{item_s1.delta_x[15]}}, item_s1.delta_x};
			nxt.pos_y      = state_q.pos_y + {{16{item_s1.delta_y[15]}}, item_s1.delta_y};
			nxt.scroll_acc = state_q.scroll_acc
				+ {{16{item_s1.delta_wheel[15]}}, item_s1.delta_wheel};
			priority if (item_s1.left_down) begin
				nxt.left_held = 1'b1;
				if (!state_q.left_held) begin
					nxt.press_seen = 1'b0;
				end else begin
					nxt.mode = MODE_BUTTON;
					if (state_q.press_seen) begin
						is_move = 1'b1;
					end else begin
						nxt.press_seen   = 1'b1;
						res.event_kind   = EV_PRESS;
						res.event_button = BTN_LEFT;
					end
				end
			end else if (item_s1.right_down) begin
				nxt.right_held = 1'b1;
				if (!state_q.right_held) begin
					nxt.press_seen = 1'b0;
				end else begin
					nxt.mode = MODE_BUTTON;
					if (state_q.press_seen) begin
						is_move = 1'b1;
					end else begin
						nxt.press_seen   = 1'b1;
						res.event_kind   = EV_PRESS;
						res.event_button = BTN_RIGHT;
					end
				end
			end else if (item_s1.wheel_down) begin
				nxt.wheel_held   = 1'b1;
				nxt.mode         = MODE_WHEEL;
				res.event_kind   = EV_PRESS;
				res.event_button = BTN_WHEEL;
			end else if (any_xy) begin
				is_move = 1'b1;
			end else if (item_s1.delta_wheel != 16'sd0) begin
				res.event_kind    = EV_SCROLL;
				res.scroll_amount = item_s1.delta_wheel;
			end else if (state_q.left_held) begin
				nxt.left_held    = 1'b0;
				nxt.mode         = MODE_NORMAL;
				res.event_kind   = state_q.press_seen ? EV_RELEASE : EV_CLICK;
				res.event_button = BTN_LEFT;
			end else if (state_q.right_held) begin
				nxt.right_held   = 1'b0;
				nxt.mode         = MODE_NORMAL;
				res.event_kind   = state_q.press_seen ? EV_RELEASE : EV_CLICK;
				res.event_button = BTN_RIGHT;
			end else if (state_q.wheel_held) begin
				nxt.wheel_held   = 1'b0;
				nxt.mode         = MODE_NORMAL;
				res.event_kind   = EV_RELEASE;
				res.event_button = BTN_WHEEL;
			end else begin
				// idle report with nothing held
				res.event_kind   = EV_NONE;
			end
			if (is_move) begin
				res.event_kind = EV_MOVE;
				res.move_x     = item_s1.delta_x;
				res.move_y     = item_s1.delta_y;
			end
		end
		res.position_x      = signed'(nxt.pos_x);
		res.position_y      = signed'(nxt.pos_y);
		res.scroll_position = signed'(nxt.scroll_acc);
		res.mouse_mode      = nxt.mode;
	end

	// Tracker state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= STATE_RESET;
			gesture_valid <= 1'b0;
		end else if (ctl.load) begin
			state_q       <= nxt;
			gesture_valid <= 1'b1;
		end else if (!gesture_stall) begin
			gesture_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			gesture <= res;
		end
	end

	`MRGC_ASSERT(a_load_needs_item, ctl.load |-> ctl.valid, "result loaded without an item")
	`MRGC_ASSERT(a_bad_keeps_pos,
		(ctl.load && item_s1.report_id != VALID_ID) |=> state_q == $past(state_q),
		"bad report changed tracker state")
	`MRGC_ASSERT_ALWAYS(a_wheel_mode,
		state_q.mode == MODE_WHEEL |-> state_q.wheel_held, "wheel mode without wheel held")
	`MRGC_ASSERT(a_button_mode,
		state_q.mode == MODE_BUTTON |-> (state_q.left_held || state_q.right_held),
		"button mode without a held button")

endmodule

[rtl/core/mouse_report_gesture_classifier_top.sv]
// Mouse report gesture classifier, top level.
// Depends on mrgc_pkg, mrgc_input_stage and mrgc_classifier.
//
// Usage:
//   Report channel (report_valid, report_stall, report) carries one HID mouse
//   report per item. Gesture channel (gesture_valid, gesture_stall, gesture)
//   returns exactly one classified gesture per report, in order.
//   Path: an accepted report waits in the input register, then is classified and
//   loaded into the result register once that is empty or its gesture is taken.
//   Throughput: one report per cycle while gesture_stall is low, set by the
//   single classifier stage, whose priority chain and three 32-bit adds fit
//   between two registers.
//   Stall: while a gesture waits under gesture_stall one more report is held
//   in the input register; report_stall rises only when both are occupied.
//   Tracker state advances when a report moves into the result register.
//   Reset: arst_n clears both valid flags and returns the accumulators to
//   x 320, y 240, scroll 240, all held flags clear, mode normal.
//   A report whose id is not 2 yields a bad_report gesture, state unchanged.
module mouse_report_gesture_classifier_top import mrgc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     report_valid,
	output logic     report_stall,
	input  report_t  report,
	output logic     gesture_valid,
	input  logic     gesture_stall,
	output gesture_t gesture
);

	logic       valid_s1;
	report_t    item_s1;
	stage_ctl_t ctl;

	// Result register takes a new item when empty or when its item leaves
	assign ctl = '{valid: valid_s1, load: valid_s1 && (!gesture_valid || !gesture_stall)};

	mrgc_input_stage u_input (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.load         (ctl.load),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	mrgc_classifier u_classifier (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_s1       (item_s1),
		.ctl           (ctl),
		.gesture_valid (gesture_valid),
		.gesture_stall (gesture_stall),
		.gesture       (gesture)
	);

endmodule

[sim/tb_mouse_report_gesture_classifier_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for mouse_report_gesture_classifier_top.
// Depends on mrgc_pkg and the classifier RTL; holds its own gesture tracker.

module tb_mouse_report_gesture_classifier_top;
	import mrgc_pkg::*;

	localparam int NUM_RANDOM    = 380;
	localparam int WRAP_REPORTS  = 40;
	localparam int LONG_HOLD     = 80;
	localparam int STUCK_LIMIT   = 2000;

	// Tracks pointer state and holds the gestures still due from the block
	class gesture_scoreboard;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] scroll_acc;
		bit          left_held;
		bit          right_held;
		bit          wheel_held;
		bit          press_seen;
		mode_t       mode;
		gesture_t    pending_q[$];
		int          mismatches;
		int          checked;
		int          kind_count[7];

		function new();
			pos_x      = RESET_X;
			pos_y      = RESET_Y;
			scroll_acc = RESET_SCR;
			left_held  = 1'b0;
			right_held = 1'b0;
			wheel_held = 1'b0;
			press_seen = 1'b0;
			mode       = MODE_NORMAL;
			mismatches = 0;
			checked    = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		// Button held down: press on its second report, moves after that
		function void button_down(bit was_held, btn_t which, inout ev_kind_t kind,
				inout btn_t button, inout bit is_move);
			if (!was_held) begin
				press_seen = 1'b0;
				return;
			end
			mode = MODE_BUTTON;
			if (press_seen) begin
				is_move = 1'b1;
			end else begin
				press_seen = 1'b1;
				kind       = EV_PRESS;
				button     = which;
			end
		endfunction

		function gesture_t classify(report_t rpt);
			gesture_t g;
			ev_kind_t kind;
			btn_t     button;
			bit       is_move;
			g       = '0;
			kind    = EV_NONE;
			button  = BTN_LEFT;
			is_move = 1'b0;
			if (rpt.report_id != VALID_ID) begin
				kind = EV_BAD;
			end else begin
				pos_x      = pos_x + {{16{rpt.delta_x[15]}}, rpt.delta_x};
				pos_y      = pos_y + {{16{rpt.delta_y[15]}}, rpt.delta_y};
				scroll_acc = scroll_acc + {{16{rpt.delta_wheel[15]}}, rpt.delta_wheel};
				if (rpt.left_down) begin
					button_down(left_held, BTN_LEFT, kind, button, is_move);
					left_held = 1'b1;
				end else if (rpt.right_down) begin
					button_down(right_held, BTN_RIGHT, kind, button, is_move);
					right_held = 1'b1;
				end else if (rpt.wheel_down) begin
					wheel_held = 1'b1;
					mode       = MODE_WHEEL;
					kind       = EV_PRESS;
					button     = BTN_WHEEL;
				end else if (rpt.delta_x != 0 || rpt.delta_y != 0) begin
					is_move = 1'b1;
				end else if (rpt.delta_wheel != 0) begin
					kind            = EV_SCROLL;
					g.scroll_amount = rpt.delta_wheel;
				end else if (left_held) begin
					left_held = 1'b0;
					mode      = MODE_NORMAL;
					kind      = press_seen ? EV_RELEASE : EV_CLICK;
					button    = BTN_LEFT;
				end else if (right_held) begin
					right_held = 1'b0;
					mode       = MODE_NORMAL;
					kind       = press_seen ? EV_RELEASE : EV_CLICK;
					button     = BTN_RIGHT;
				end else if (wheel_held) begin
					wheel_held = 1'b0;
					mode       = MODE_NORMAL;
					kind       = EV_RELEASE;
					button     = BTN_WHEEL;
				end
				if (is_move) begin
					kind     = EV_MOVE;
					g.move_x = rpt.delta_x;
					g.move_y = rpt.delta_y;
				end
			end
			g.event_kind      = kind;
			g.event_button    = button;
			g.position_x      = pos_x;
			g.position_y      = pos_y;
			g.scroll_position = scroll_acc;
			g.mouse_mode      = mode;
			return g;
		endfunction

		function void note_report(report_t rpt);
			pending_q.push_back(classify(rpt));
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
			$display("[%0t] MISMATCH gesture %0d %s: got %h, expected %h",
				$time, checked, field, got, want);
			mismatches++;
		endtask

		task check_gesture(gesture_t g);
			gesture_t e;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected gesture, kind", g.event_kind, 0);
				return;
			end
			e = pending_q.pop_front();
			if (g.event_kind !== e.event_kind)
				report_mismatch("event_kind", g.event_kind, e.event_kind);
			if (g.event_button !== e.event_button)
				report_mismatch("event_button", g.event_button, e.event_button);
			if (g.move_x !== e.move_x)
				report_mismatch("move_x", g.move_x, e.move_x);
			if (g.move_y !== e.move_y)
				report_mismatch("move_y", g.move_y, e.move_y);
			if (g.scroll_amount !== e.scroll_amount)
				report_mismatch("scroll_amount", g.scroll_amount, e.scroll_amount);
			if (g.position_x !== e.position_x)
				report_mismatch("position_x", g.position_x, e.position_x);
			if (g.position_y !== e.position_y)
				report_mismatch("position_y", g.position_y, e.position_y);
			if (g.scroll_position !== e.scroll_position)
				report_mismatch("scroll_position", g.scroll_position, e.scroll_position);
			if (g.mouse_mode !== e.mouse_mode)
				report_mismatch("mouse_mode", g.mouse_mode, e.mouse_mode);
			kind_count[e.event_kind]++;
			checked++;
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     report_valid = 1'b0;
	logic     report_stall;
	report_t  report_item = '0;
	logic     gesture_valid;
	logic     gesture_stall = 1'b0;
	gesture_t gesture_out;

	gesture_scoreboard tracker = new();

	bit src_idle  = 1'b0;
	bit sink_idle = 1'b0;
	bit hold_req  = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int reports_sent = 0;
	int stuck_cycles = 0;

	mouse_report_gesture_classifier_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.report_valid  (report_valid),
		.report_stall  (report_stall),
		.report        (report_item),
		.gesture_valid (gesture_valid),
		.gesture_stall (gesture_stall),
		.gesture       (gesture_out)
	);

	always #6 clk = ~clk;

	// Receiver: random stall bursts, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			gesture_stall = 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			gesture_stall = 1'b1;
			stall_left--;
		end else if (sink_idle && $urandom_range(0, 4) == 0) begin
			gesture_stall = 1'b1;
			stall_left    = $urandom_range(0, 4);
		end else begin
			gesture_stall = 1'b0;
		end
	end

	// Gesture monitor and watchdog
	always @(posedge clk) begin
		if (arst_n && gesture_valid && !gesture_stall)
			tracker.check_gesture(gesture_out);
		if ((report_valid && !report_stall) || (arst_n && gesture_valid && !gesture_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[%0t] watchdog: no item moved for %0d cycles, %0d gestures pending",
				$time, STUCK_LIMIT, tracker.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic report_t make_report(logic [7:0] id, logic l, logic r, logic w,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] dw);
		report_t rpt;
		rpt.report_id   = id;
		rpt.left_down   = l;
		rpt.right_down  = r;
		rpt.wheel_down  = w;
		rpt.delta_x     = dx;
		rpt.delta_y     = dy;
		rpt.delta_wheel = dw;
		return rpt;
	endfunction

	// Small motion most often, with zeros, extremes and full-range values mixed in
	function automatic logic [15:0] rand_delta();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'h7fff;
			2:       return 16'h8000;
			3, 4, 5: return 16'($urandom_range(0, 20) - 10);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one item at the falling edge and hold it until accepted
	task automatic send_report(report_t rpt);
		int gap;
		if (src_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			report_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		report_valid = 1'b1;
		report_item  = rpt;
		do @(posedge clk); while (report_stall);
		tracker.note_report(rpt);
		reports_sent++;
		@(negedge clk);
		report_valid = 1'b0;
	endtask

	task automatic send_zero_report();
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
	endtask

	// One random gesture: press/hold/release, motion, scroll or idle, plus some noise
	task automatic send_gesture_sequence();
		int pick;
		int n;
		logic [2:0] btns;
		pick = $urandom_range(0, 11);
		case (pick)
			0, 1, 2, 3: begin
				btns = 3'b001 << $urandom_range(0, 2);
				if ($urandom_range(0, 3) == 0)
					btns = btns | 3'($urandom);
				n = (pick == 3) ? 1 : $urandom_range(2, 6);
				repeat (n) begin
					send_report(make_report(VALID_ID, btns[0], btns[1], btns[2],
						rand_delta(), rand_delta(), rand_delta()));
				end
				// one zero report per button of the chord, each releasing a held button if any
				repeat ($countones(btns)) send_zero_report();
			end
			4, 5: begin
				repeat ($urandom_range(1, 4))
					send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0,
						rand_delta(), rand_delta(), rand_delta()));
			end
			6: begin
				send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0,
					rand_delta()));
			end
			7, 8: begin
				send_report(make_report(8'($urandom), 1'($urandom), 1'($urandom),
					1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
			end
			9, 10: begin
				// broken sequences: random buttons, release with motion
				send_report(make_report(VALID_ID, 1'($urandom), 1'($urandom),
					1'($urandom), rand_delta(), rand_delta(), rand_delta()));
			end
			default: send_zero_report();
		endcase
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: bad ids, extremes, click, press/hold/release per button
		send_report(make_report(8'h00, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
		send_report(make_report(8'hff, 1'b1, 1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff));
		send_report(make_report(8'h03, 1'b1, 1'b0, 1'b1, 16'h7fff, 16'h8000, 16'h7fff));
		send_zero_report();
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h7fff, 16'h8000, 16'h0));
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h7fff, 16'h1));
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0001, 16'h0));
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h7fff));
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h8000));
		send_report(make_report(VALID_ID, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
		send_zero_report();
		send_report(make_report(VALID_ID, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
		send_report(make_report(VALID_ID, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
		send_report(make_report(VALID_ID, 1'b1, 1'b0, 1'b0, 16'h0005, 16'hfffb, 16'h0));
		send_report(make_report(8'h01, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
		send_zero_report();
		send_report(make_report(VALID_ID, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0));
		send_zero_report();
		send_report(make_report(VALID_ID, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0));
		send_report(make_report(VALID_ID, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0003));
		send_zero_report();
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b1, 16'h0, 16'h0, 16'h0));
		send_report(make_report(VALID_ID, 1'b0, 1'b0, 1'b1, 16'h0, 16'h0, 16'h0));
		send_zero_report();
		send_report(make_report(VALID_ID, 1'b1, 1'b1, 1'b1, 16'h0, 16'h0, 16'h0));
		send_report(make_report(VALID_ID, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0));
		send_zero_report();
		send_zero_report();

		// Large-delta sweep: back-to-back extreme deltas with random buttons
		repeat (WRAP_REPORTS) begin
			send_report(make_report(VALID_ID, 1'($urandom), 1'($urandom), 1'($urandom),
				16'h7fff, 16'h8000, 16'h7fff));
		end
		send_zero_report();
		send_zero_report();
		send_zero_report();

		// Random gestures with idling on both sides
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		begin : random_phase
			int start_count;
			bit held_off;
			start_count = reports_sent;
			held_off    = 1'b0;
			while (reports_sent - start_count < NUM_RANDOM) begin
				if (!held_off && reports_sent - start_count > 150) begin
					hold_req = 1'b1;
					held_off = 1'b1;
				end
				if (reports_sent - start_count > NUM_RANDOM - 70) begin
					src_idle  = 1'b0;
					sink_idle = 1'b0;
				end
				send_gesture_sequence();
			end
		end

		// Drain the gesture channel
		while (tracker.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("Covered %0d reports: directed cases, large-delta sweep, random gestures",
			reports_sent);
		$display("Checked %0d: none %0d move %0d press %0d click %0d release %0d scroll %0d bad %0d",
			tracker.checked, tracker.kind_count[EV_NONE], tracker.kind_count[EV_MOVE],
			tracker.kind_count[EV_PRESS], tracker.kind_count[EV_CLICK],
			tracker.kind_count[EV_RELEASE], tracker.kind_count[EV_SCROLL],
			tracker.kind_count[EV_BAD]);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mrgc_pkg.sv
rtl/core/mrgc_input_stage.sv
rtl/core/mrgc_classifier.sv
rtl/core/mouse_report_gesture_classifier_top.sv
sim/tb_mouse_report_gesture_classifier_top.sv
